/* rtl/core/lrs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lrs_pkg: shared types and constants of the radix record sorter
// Item layouts for both channels, the stored entry layout, the control
// bundle of the digit count unit and the divide-by-ten helper.
// ----------------------------------------------------------------------------
package lrs_pkg;

   localparam int LRS_CAPACITY = 64;
   localparam int KEY_BITS     = 16;
   localparam int PAYLOAD_BITS = 32;
   localparam int RADIX        = 10;
   localparam int DIGIT_W      = 4;

   // x / 10 == (x * 52429) >> 19 holds exactly for every 16-bit x.
   localparam int DIV10_MUL   = 52429;
   localparam int DIV10_SHIFT = 19;

   typedef struct packed {
      logic [KEY_BITS-1:0]     key_in;
      logic [PAYLOAD_BITS-1:0] payload_in;
      logic                    last_in;
   } req_item_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]     key_out;
      logic [PAYLOAD_BITS-1:0] payload_out;
      logic                    last_out;
      logic                    overflow;
   } rsp_item_type;

   // One stored record plus the key quotient left for the digits still to come.
   typedef struct packed {
      logic [KEY_BITS-1:0]     key;
      logic [PAYLOAD_BITS-1:0] payload;
      logic [KEY_BITS-1:0]     quo;
   } entry_type;

   typedef struct packed {
      logic               clear;
      logic               count;
      logic               prefix;
      logic               take;
      logic [DIGIT_W-1:0] digit;
   } cnt_ctrl_type;

   function automatic logic [KEY_BITS-1:0] div10(input logic [KEY_BITS-1:0] x);
      logic [2*KEY_BITS-1:0] prod;
      prod = {{KEY_BITS{1'b0}}, x} * (2*KEY_BITS)'(DIV10_MUL);
      return KEY_BITS'(prod >> DIV10_SHIFT);
   endfunction

endpackage
`default_nettype wire

/* rtl/core/lrs_bucket_counts.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lrs_bucket_counts: per-digit counters of one radix pass
// Holds the ten bucket counts, turns them into start offsets with an
// exclusive prefix sum (one bucket per cycle) and hands out scatter slots.
// ----------------------------------------------------------------------------
module lrs_bucket_counts import lrs_pkg::*; #(
   parameter int CAPACITY = LRS_CAPACITY
) (
   input  logic                             clock,
   input  logic                             reset,
   input  cnt_ctrl_type                     ctrl,
   output logic                             prefix_done,
   output logic [$clog2(CAPACITY+1)-1:0]    take_pos
);

   localparam int CNT_W = $clog2(CAPACITY+1);

   logic [CNT_W-1:0]   cnt_ff [RADIX];
   logic [CNT_W-1:0]   cnt_in [RADIX];
   logic [CNT_W-1:0]   run_ff, run_in;
   logic [DIGIT_W-1:0] pidx_ff, pidx_in;

   always_comb begin
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      pidx_in = pidx_ff;
      if (ctrl.clear) begin
         for (int i = 0; i < RADIX; i++) begin
            cnt_in[i] = '0;
         end
         run_in  = '0;
         pidx_in = '0;
      end else if (ctrl.count || ctrl.take) begin
         cnt_in[ctrl.digit] = cnt_ff[ctrl.digit] + CNT_W'(1);
      end else if (ctrl.prefix) begin
         cnt_in[pidx_ff] = run_ff;
         run_in          = run_ff + cnt_ff[pidx_ff];
         pidx_in         = pidx_ff + DIGIT_W'(1);
      end
   end

   assign take_pos    = cnt_ff[ctrl.digit];
   assign prefix_done = ctrl.prefix && (pidx_ff == DIGIT_W'(RADIX-1));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RADIX; i++) begin
            cnt_ff[i] <= '0;
         end
         run_ff  <= '0;
         pidx_ff <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         pidx_ff <= pidx_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/lsd_radix_record_sorter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lsd_radix_record_sorter: stable base-10 LSD radix sort of a record set
// Loads records until one marked last, sorts them by key one decimal digit
// per pass between two record memories, then streams them out in order.
// ----------------------------------------------------------------------------
//
//   channel | ports                          | moves
//   --------+--------------------------------+-------------------------------
//   input   | req_valid, req_stall, req_data | one record (key, payload, last)
//   result  | rsp_valid, rsp_stall, rsp_data | one sorted record with flags
//
// Loading accepts one item per cycle. After the last item, each digit pass
// runs a setup step, a count sweep over the record memory, a prefix sum over
// the ten buckets and a scatter sweep into the other memory; there are as
// many passes as the largest key has decimal digits. While emitting, the
// next record is read only after the previous one has moved on to the
// output register, as the record memory has a registered read in front of
// it. Reset is synchronous and active high; the memories need no
// clearing because only entries below the fill count are ever read. A stall
// on the result side holds the output register and pauses the read sweep.
//
module lsd_radix_record_sorter import lrs_pkg::*; #(
   parameter int CAPACITY = LRS_CAPACITY
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   localparam int CNT_W  = $clog2(CAPACITY+1);
   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   typedef enum logic [5:0] {
      ST_LOAD    = 6'b000001,
      ST_PASS    = 6'b000010,
      ST_COUNT   = 6'b000100,
      ST_PREFIX  = 6'b001000,
      ST_SCATTER = 6'b010000,
      ST_EMIT    = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [KEY_BITS-1:0] largest_ff, largest_in;
   logic                dropped_ff, dropped_in;
   logic [KEY_BITS-1:0] rem_ff, rem_in;
   logic                sel_ff, sel_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                rd_v_ff, rd_v_in;
   logic                dig_v_ff, dig_v_in;
   logic                out_v_ff, out_v_in;
   rsp_item_type        out_ff, out_in;
   logic [DIGIT_W-1:0]  dig_ff;
   entry_type           stg_ff;

   // Two record memories; sel_ff names the one holding the current order.
   entry_type           mem_a [CAPACITY];
   entry_type           mem_b [CAPACITY];
   entry_type           rd_a_ff, rd_b_ff;
   logic                wr_a, wr_b, rd_en;
   logic [ADDR_W-1:0]   wr_addr, rd_addr;
   entry_type           wr_data;

   cnt_ctrl_type        cnt_ctrl;
   logic                prefix_done;
   logic [CNT_W-1:0]    take_pos;

   entry_type           rd_entry;
   logic [KEY_BITS-1:0] q10_w, tenq_w, dig_full_w;
   logic                req_acc, rsp_take, sweep_done;

   lrs_bucket_counts #(
      .CAPACITY(CAPACITY)
   ) u_counts (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (cnt_ctrl),
      .prefix_done (prefix_done),
      .take_pos    (take_pos)
   );

   // Digit extraction on the memory read data: quotient by ten and remainder.
   assign rd_entry   = sel_ff ? rd_b_ff : rd_a_ff;
   assign q10_w      = div10(rd_entry.quo);
   assign tenq_w     = (q10_w << 3) + (q10_w << 1);
   assign dig_full_w = rd_entry.quo - tenq_w;

   assign req_acc    = req_valid && !req_stall;
   assign rsp_take   = out_v_ff && !rsp_stall;
   assign sweep_done = (idx_ff == fill_ff) && !rd_v_ff && !dig_v_ff;

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      largest_in = largest_ff;
      dropped_in = dropped_ff;
      rem_in     = rem_ff;
      sel_in     = sel_ff;
      idx_in     = idx_ff;
      rd_v_in    = 1'b0;
      dig_v_in   = rd_v_ff && (state_ff == ST_COUNT || state_ff == ST_SCATTER);
      out_v_in   = out_v_ff && !rsp_take;
      out_in     = out_ff;
      wr_a       = 1'b0;
      wr_b       = 1'b0;
      wr_addr    = fill_ff[ADDR_W-1:0];
      wr_data    = '{key: req_data.key_in, payload: req_data.payload_in,
                     quo: req_data.key_in};
      rd_en      = 1'b0;
      rd_addr    = idx_ff[ADDR_W-1:0];
      cnt_ctrl   = '{clear: 1'b0, count: 1'b0, prefix: 1'b0, take: 1'b0,
                     digit: dig_ff};

      case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               if (fill_ff < CNT_W'(CAPACITY)) begin
                  wr_a    = !sel_ff;
                  wr_b    = sel_ff;
                  fill_in = fill_ff + CNT_W'(1);
                  if (req_data.key_in > largest_ff) begin
                     largest_in = req_data.key_in;
                  end
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_data.last_in) begin
                  rem_in   = largest_in;
                  state_in = ST_PASS;
               end
            end
         end
         ST_PASS: begin
            // A remaining key quotient of zero means every digit is done.
            cnt_ctrl.clear = 1'b1;
            idx_in         = '0;
            state_in       = (rem_ff == '0) ? ST_EMIT : ST_COUNT;
         end
         ST_COUNT: begin
            if (idx_ff < fill_ff) begin
               rd_en   = 1'b1;
               rd_v_in = 1'b1;
               idx_in  = idx_ff + CNT_W'(1);
            end
            cnt_ctrl.count = dig_v_ff;
            if (sweep_done) begin
               state_in = ST_PREFIX;
            end
         end
         ST_PREFIX: begin
            cnt_ctrl.prefix = 1'b1;
            idx_in          = '0;
            if (prefix_done) begin
               state_in = ST_SCATTER;
            end
         end
         ST_SCATTER: begin
            if (idx_ff < fill_ff) begin
               rd_en   = 1'b1;
               rd_v_in = 1'b1;
               idx_in  = idx_ff + CNT_W'(1);
            end
            // Each record goes to the next free slot of its digit's bucket
            // in the other memory, so records of equal digit keep their order.
            cnt_ctrl.take = dig_v_ff;
            wr_addr       = take_pos[ADDR_W-1:0];
            wr_data       = stg_ff;
            wr_a          = dig_v_ff && sel_ff;
            wr_b          = dig_v_ff && !sel_ff;
            // The swap waits until the sweep has drained, so no read or
            // write of the finished pass is still in flight.
            if (sweep_done) begin
               sel_in   = !sel_ff;
               rem_in   = div10(rem_ff);
               state_in = ST_PASS;
            end
         end
         ST_EMIT: begin
            if ((idx_ff < fill_ff) && !rd_v_ff && (!out_v_ff || !rsp_stall)) begin
               rd_en   = 1'b1;
               rd_v_in = 1'b1;
               idx_in  = idx_ff + CNT_W'(1);
            end
            if (rd_v_ff) begin
               out_v_in = 1'b1;
               out_in   = '{key_out: rd_entry.key, payload_out: rd_entry.payload,
                            last_out: (idx_ff == fill_ff), overflow: dropped_ff};
            end
            if ((idx_ff == fill_ff) && !rd_v_ff) begin
               fill_in    = '0;
               largest_in = '0;
               dropped_in = 1'b0;
               idx_in     = '0;
               state_in   = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_LOAD);
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_a[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         mem_b[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_b_ff <= mem_b[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_v_ff) begin
         dig_ff <= dig_full_w[DIGIT_W-1:0];
         stg_ff <= '{key: rd_entry.key, payload: rd_entry.payload, quo: q10_w};
      end
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         fill_ff    <= '0;
         largest_ff <= '0;
         dropped_ff <= 1'b0;
         rem_ff     <= '0;
         sel_ff     <= 1'b0;
         idx_ff     <= '0;
         rd_v_ff    <= 1'b0;
         dig_v_ff   <= 1'b0;
         out_v_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         largest_ff <= largest_in;
         dropped_ff <= dropped_in;
         rem_ff     <= rem_in;
         sel_ff     <= sel_in;
         idx_ff     <= idx_in;
         rd_v_ff    <= rd_v_in;
         dig_v_ff   <= dig_v_in;
         out_v_ff   <= out_v_in;
      end
   end

   // The scatter slot of a record always lies inside the loaded set.
   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCATTER && dig_v_ff) |-> (take_pos < fill_ff))
      else $error("scatter slot beyond the loaded set");

   // The memories swap roles only after the read pipeline has drained.
   a_swap_drained: assert property (@(posedge clock) disable iff (reset)
      (sel_ff != $past(sel_ff)) |-> $past(!rd_v_ff && !dig_v_ff))
      else $error("memory swap with a read still in flight");

   // Read data arriving during emission always finds the output register free.
   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rd_v_ff) |-> !out_v_ff)
      else $error("emitted record would overwrite a waiting item");

   // The fill count never passes the memory depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (fill_ff <= CNT_W'(CAPACITY)))
      else $error("fill count beyond capacity");

endmodule
`default_nettype wire
